/* hw/rtl/keyed_bitmap_presence_table_macros.svh */
// Assertion macros shared by the keyed bitmap presence table RTL.
// No dependencies; define ASSERT_OFF to compile the assertions away.
`ifndef KEYED_BITMAP_PRESENCE_TABLE_MACROS_SVH
`define KEYED_BITMAP_PRESENCE_TABLE_MACROS_SVH
`ifndef ASSERT_OFF
`define KBPT_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define KBPT_ASSERT_NEXT(lbl, clk, rst_n, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);
`else
`define KBPT_ASSERT(lbl, clk, rst_n, prop, msg)
`define KBPT_ASSERT_NEXT(lbl, clk, rst_n, pre, post, msg)
`endif
`endif

/* hw/rtl/kbpt_pkg.sv */
// Package for the keyed bitmap presence table: sizes, hash constants,
// operation and status codes, and the packed slot entry. No dependencies.
package kbpt_pkg;

	localparam int TABLE_SLOTS   = 32;
	localparam int ITEMS_PER_KEY = 64;

	localparam int SLOT_W  = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
	localparam int BIT_W   = (ITEMS_PER_KEY > 1) ? $clog2(ITEMS_PER_KEY) : 1;

	localparam logic [31:0] HASH_BASIS = 32'd2166136261;
	localparam logic [31:0] HASH_PRIME = 32'd16777619;

	localparam logic [1:0] OP_LOCATE = 2'd0;
	localparam logic [1:0] OP_TEST   = 2'd1;
	localparam logic [1:0] OP_SET    = 2'd2;

	localparam logic [2:0] ST_FOUND     = 3'd0;
	localparam logic [2:0] ST_CREATED   = 3'd1;
	localparam logic [2:0] ST_COLLISION = 3'd2;
	localparam logic [2:0] ST_FULL      = 3'd3;
	localparam logic [2:0] ST_BAD_ID    = 3'd4;

	typedef struct packed {
		logic [31:0]              hash;
		logic [31:0]              sig;
		logic [ITEMS_PER_KEY-1:0] bits;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

endpackage

/* hw/rtl/kbpt_ram.sv */
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module kbpt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input  logic                                      clk,
	input  logic                                      we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                          wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                          rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

/* hw/rtl/keyed_bitmap_presence_table.sv */
// Keyed bitmap presence table, top level. Uses kbpt_pkg, kbpt_ram and the
// assertion macros header.
//
// A key name arrives as a stream of byte requests on the input channel
// (in_valid / in_ready), one byte per request, with name_last on the final
// byte. Ordinary name bytes are taken one per cycle while in_ready is high:
// each is folded into an FNV-1a hash by a single 32-bit multiply and the
// first four bytes are kept as a signature. The last byte also carries the
// operation and item id. That request starts a slot scan in a small
// sequencer that reuses one compare unit against one slot entry at a time,
// read from a slot RAM. A free slot ends the scan in S_SCAN; every occupied
// slot it passes costs an S_SCAN step (RAM read), then an S_CMP step
// (compare). The result is registered when the key is created in a free slot,
// when it is found or collides at a matching hash, or when the last slot misses
// and the table is full. An out-of-range id on a test or set skips the scan;
// its result is registered at the taking edge itself.
// Each result waits in an output register until out_ready takes it; while
// a result is held and not taken, and during a scan, in_ready stays low.
// Reset clears the per-slot valid bits, so the table is empty at once and
// no clearing pass is needed; the hash and signature restart as well.
`include "keyed_bitmap_presence_table_macros.svh"
module keyed_bitmap_presence_table (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] name_byte,
	input  logic       name_last,
	input  logic [1:0] operation,
	input  logic [7:0] item_id,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [2:0] status,
	output logic       collected,
	output logic [4:0] slot_index
);
	import kbpt_pkg::*;

	localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(TABLE_SLOTS - 1);

	// One-hot sequencer states.
	typedef enum logic [2:0] {
		S_IDLE = 3'b001,
		S_SCAN = 3'b010,
		S_CMP  = 3'b100
	} state_t;

	state_t                   state_q;
	logic [31:0]              run_hash_q;
	logic [31:0]              sig_acc_q;
	logic [2:0]               bytes_seen_q;
	logic [TABLE_SLOTS-1:0]   slot_valid_q;

	// Key under lookup and the decoded operation.
	logic [31:0]              key_hash_q;
	logic [31:0]              key_sig_q;
	logic                     op_ts_q;
	logic                     op_set_q;
	logic [BIT_W-1:0]         bit_idx_q;
	logic [SLOT_W-1:0]        idx_q;

	// Output register.
	logic                     out_valid_q;
	logic [2:0]               status_q;
	logic                     collected_q;
	logic [SLOT_W-1:0]        slot_q;

	logic                     accept;
	logic                     out_free;
	logic                     result_set;
	logic [31:0]              hash_next;
	logic [31:0]              sig_next;
	logic                     op_ts;
	logic                     bad_id;
	logic [BIT_W-1:0]         bit_idx;
	logic [ITEMS_PER_KEY-1:0] mask;
	logic [ITEMS_PER_KEY-1:0] merged_bits;
	entry_t                   rd_entry;
	entry_t                   wr_entry;
	logic [ENTRY_W-1:0]       rd_data;
	logic                     ram_we;
	logic                     hash_hit;
	logic                     sig_hit;

	// The output register can take a new result when empty or being drained.
	assign out_free = !out_valid_q || out_ready;
	assign in_ready = (state_q == S_IDLE) && out_free;
	assign accept   = in_valid && in_ready;

	// FNV-1a step: xor the byte in, then one multiply by the prime.
	assign hash_next = (run_hash_q ^ {24'd0, name_byte}) * HASH_PRIME;
	assign sig_next  = bytes_seen_q[2] ? sig_acc_q
	                 : (sig_acc_q | ({24'd0, name_byte} << {bytes_seen_q[1:0], 3'b000}));

	assign op_ts   = (operation == OP_TEST) || (operation == OP_SET);
	assign bad_id  = op_ts && ((item_id == 8'd0) || (item_id > 8'(ITEMS_PER_KEY)));
	assign bit_idx = BIT_W'(item_id - 8'd1);

	assign mask        = ITEMS_PER_KEY'(1) << bit_idx_q;
	assign rd_entry    = entry_t'(rd_data);
	assign hash_hit    = rd_entry.hash == key_hash_q;
	assign sig_hit     = rd_entry.sig == key_sig_q;
	assign merged_bits = rd_entry.bits | mask;

	// A result is produced by a rejected id, by a free slot, or by the compare
	// that ends the scan on a hash match or on the last slot.
	assign result_set = (state_q == S_IDLE && accept && name_last && bad_id)
	                 || (state_q == S_SCAN && !slot_valid_q[idx_q])
	                 || (state_q == S_CMP && (hash_hit || idx_q == SLOT_LAST));

	// A new entry is written on creation; a found entry is written back
	// only when a set adds its bit.
	always_comb begin
		wr_entry.hash = key_hash_q;
		wr_entry.sig  = key_sig_q;
		wr_entry.bits = op_set_q ? mask : '0;
		ram_we        = 1'b0;
		if (state_q == S_SCAN && !slot_valid_q[idx_q]) begin
			ram_we = 1'b1;
		end else if (state_q == S_CMP && hash_hit && sig_hit && op_set_q) begin
			wr_entry.bits = merged_bits;
			ram_we        = 1'b1;
		end
	end

	kbpt_ram #(
		.WIDTH (ENTRY_W),
		.DEPTH (TABLE_SLOTS)
	) u_slot_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (idx_q),
		.wdata (wr_entry),
		.raddr (idx_q),
		.rdata (rd_data)
	);

	// Control state: sequencer, byte accumulators, valid bits, output valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			run_hash_q   <= HASH_BASIS;
			sig_acc_q    <= '0;
			bytes_seen_q <= '0;
			slot_valid_q <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			out_valid_q <= result_set || (out_valid_q && !out_ready);
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (name_last) begin
							run_hash_q   <= HASH_BASIS;
							sig_acc_q    <= '0;
							bytes_seen_q <= '0;
							if (!bad_id) begin
								state_q <= S_SCAN;
							end
						end else begin
							run_hash_q <= hash_next;
							sig_acc_q  <= sig_next;
							if (!bytes_seen_q[2]) begin
								bytes_seen_q <= bytes_seen_q + 3'd1;
							end
						end
					end
				end
				S_SCAN: begin
					if (!slot_valid_q[idx_q]) begin
						slot_valid_q[idx_q] <= 1'b1;
						state_q             <= S_IDLE;
					end else begin
						state_q <= S_CMP;
					end
				end
				S_CMP: begin
					if (hash_hit || idx_q == SLOT_LAST) begin
						state_q <= S_IDLE;
					end else begin
						state_q <= S_SCAN;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Key, scan index and result payload.
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (accept && name_last) begin
					key_hash_q <= hash_next;
					key_sig_q  <= sig_next;
					op_ts_q    <= op_ts;
					op_set_q   <= (operation == OP_SET);
					bit_idx_q  <= bit_idx;
					idx_q      <= '0;
					if (bad_id) begin
						status_q    <= ST_BAD_ID;
						collected_q <= 1'b0;
						slot_q      <= '0;
					end
				end
			end
			S_SCAN: begin
				if (!slot_valid_q[idx_q]) begin
					status_q    <= ST_CREATED;
					collected_q <= op_set_q;
					slot_q      <= idx_q;
				end
			end
			S_CMP: begin
				if (hash_hit) begin
					if (sig_hit) begin
						status_q    <= ST_FOUND;
						collected_q <= op_ts_q && (op_set_q || rd_entry.bits[bit_idx_q]);
						slot_q      <= idx_q;
					end else begin
						status_q    <= ST_COLLISION;
						collected_q <= 1'b0;
						slot_q      <= '0;
					end
				end else if (idx_q == SLOT_LAST) begin
					status_q    <= ST_FULL;
					collected_q <= 1'b0;
					slot_q      <= '0;
				end else begin
					idx_q <= idx_q + SLOT_W'(1);
				end
			end
			default: begin
			end
		endcase
	end

	assign out_valid  = out_valid_q;
	assign status     = status_q;
	assign collected  = collected_q;
	assign slot_index = 5'(slot_q);

	// A slot reported as created must be marked occupied.
	`KBPT_ASSERT(a_created_slot_valid, clk, arst_n, ($rose(out_valid_q) && status_q == ST_CREATED) |-> slot_valid_q[slot_q], "created slot is not marked valid")
	// A miss on the last slot must end the scan with a full result.
	`KBPT_ASSERT_NEXT(a_full_after_last_miss, clk, arst_n, state_q == S_CMP && !hash_hit && idx_q == SLOT_LAST, out_valid_q && status_q == ST_FULL && state_q == S_IDLE, "last-slot miss did not report table full")
	// A result only appears after a scan step or a last-byte request.
	`KBPT_ASSERT(a_result_source, clk, arst_n, $rose(out_valid_q) |-> $past(state_q != S_IDLE || (in_valid && in_ready && name_last)), "result raised without a lookup")

endmodule
